/* rtl/core/dam_pkg.sv */
package dam_pkg;

	// field widths
	localparam int MODE_W = 2;
	localparam int ADDR_W = 7;
	localparam int MAG_W  = 14;
	localparam int WORD_W = MAG_W + 1;
	localparam int PC_W   = 7;
	localparam int OP_W   = 7;
	localparam int STAT_W = 3;
	localparam int ACC_W  = 15;

	// largest decimal magnitude of a word
	localparam logic [MAG_W-1:0] MAG_MAX = 14'd9999;

	// input tdata layout, lowest bit first
	localparam int IN_MODE_LSB = 0;
	localparam int IN_ADDR_LSB = IN_MODE_LSB + MODE_W;
	localparam int IN_NEG_LSB  = IN_ADDR_LSB + ADDR_W;
	localparam int IN_MAG_LSB  = IN_NEG_LSB + 1;
	localparam int IN_FIELD_W  = IN_MAG_LSB + MAG_W;
	localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

	// output tdata layout, lowest bit first
	localparam int OUT_STAT_LSB  = 0;
	localparam int OUT_VALID_LSB = OUT_STAT_LSB + STAT_W;
	localparam int OUT_NEG_LSB   = OUT_VALID_LSB + 1;
	localparam int OUT_MAG_LSB   = OUT_NEG_LSB + 1;
	localparam int OUT_PC_LSB    = OUT_MAG_LSB + MAG_W;
	localparam int OUT_ACC_LSB   = OUT_PC_LSB + PC_W;
	localparam int OUT_OVF_LSB   = OUT_ACC_LSB + ACC_W;
	localparam int OUT_FIELD_W   = OUT_OVF_LSB + 1;
	localparam int OUT_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELD_W;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK          = 3'd0,
		ST_HALTED      = 3'd1,
		ST_DIV_ZERO    = 3'd2,
		ST_UNKNOWN     = 3'd3,
		ST_PAST_END    = 3'd4,
		ST_NOT_RUNNING = 3'd5
	} status_t;

	// item modes
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd3;

	// opcodes
	localparam logic [OP_W-1:0] OP_READ    = 7'd10;
	localparam logic [OP_W-1:0] OP_WRITE   = 7'd11;
	localparam logic [OP_W-1:0] OP_LOAD    = 7'd20;
	localparam logic [OP_W-1:0] OP_STORE   = 7'd21;
	localparam logic [OP_W-1:0] OP_ADD     = 7'd30;
	localparam logic [OP_W-1:0] OP_SUB     = 7'd31;
	localparam logic [OP_W-1:0] OP_DIV     = 7'd32;
	localparam logic [OP_W-1:0] OP_MUL     = 7'd33;
	localparam logic [OP_W-1:0] OP_BRANCH  = 7'd40;
	localparam logic [OP_W-1:0] OP_BRNEG   = 7'd41;
	localparam logic [OP_W-1:0] OP_BRZERO  = 7'd42;
	localparam logic [OP_W-1:0] OP_HALT    = 7'd43;
	localparam logic [OP_W-1:0] OP_SHR     = 7'd50;

endpackage

/* rtl/core/decimal_accumulator_machine.sv */
// path to the result: write and start items and idle steps pass dispatch and done, reads
// add the registered memory read, executed instructions add fetch, decode, operand read
// and execute; MUL adds saturation, SHR quotient, remainder and scale steps, and DIV a
// fourteen-step restoring divider (one quotient bit per cycle) and a sign step
// throughput: one item at a time, the next item is taken once its result is registered
// reset: arst_n clears the valid bits (all words read plus zero), acc, pc and running
module decimal_accumulator_machine #(
	parameter int MEMORY_WORDS = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// mode[1:0], address[8:2], word_negative[9], word_magnitude[23:10]
	input  logic [dam_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status[2:0], out_valid[3], out_negative[4], out_magnitude[18:5],
	// program_counter[25:19], acc_value[40:26], overflow[41], zeros above
	output logic [dam_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dam_pkg::*;

	localparam int IDX_W = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
	localparam logic [ADDR_W-1:0] MW_ADDR = ADDR_W'(MEMORY_WORDS);

	// reciprocal constants for the decimal splits, exact for magnitudes up to 9999
	localparam logic [26:0] RECIP100   = 27'd5243;   // x/100  = (x*5243)  >> 19
	localparam logic [28:0] RECIP1000  = 29'd16778;  // x/1000 = (x*16778) >> 24
	localparam logic [3:0]  DIV_LAST   = 4'(MAG_W - 1);

	localparam logic signed [ACC_W:0]   SUM_MAX = 16'sd9999;
	localparam logic signed [ACC_W:0]   SUM_MIN = -16'sd9999;
	localparam logic signed [2*ACC_W-1:0] PROD_MAX = 30'sd9999;
	localparam logic signed [2*ACC_W-1:0] PROD_MIN = -30'sd9999;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 15'sd9999;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -15'sd9999;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_DATA,
		S_IR_DATA,
		S_DEC_Q,
		S_DEC_R,
		S_OPND_RD,
		S_OPND_DATA,
		S_EXEC,
		S_DIV_STEP,
		S_DIV_DONE,
		S_MUL_SAT,
		S_SHR_Q,
		S_SHR_R,
		S_SHR_SCALE,
		S_DONE
	} state_t;

	state_t state_q;

	// accepted item
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic              item_neg_q;
	logic [MAG_W-1:0]  item_mag_q;

	// architectural state besides the memory
	logic signed [ACC_W-1:0] acc_q;
	logic [PC_W-1:0]         pc_q;
	logic                    running_q;

	// instruction decode
	word_t           ir_q;
	logic [OP_W-1:0] opq_q;
	logic [OP_W-1:0] op_q;
	logic [OP_W-1:0] opnd_q;
	logic            opnd_ok_q;
	word_t           opw_q;

	// multi-cycle units
	logic [MAG_W-1:0]          div_rem_q;
	logic [MAG_W-1:0]          div_quo_q;
	logic [3:0]                div_cnt_q;
	logic                      div_neg_q;
	logic signed [2*ACC_W-1:0] prod_q;
	logic [3:0]                shr_quo_q;
	logic [9:0]                shr_rem_q;

	// result under construction
	status_t res_status_q;
	logic    res_valid_q;
	word_t   res_word_q;
	logic    res_ovf_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;

	// memory with one write and one registered read port
	word_t             mem_q [MEMORY_WORDS];
	logic [MEMORY_WORDS-1:0] word_vld_q;
	word_t             rd_word_q;
	logic              rd_vld_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_widx;
	word_t             mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ridx;
	word_t             rd_masked;

	// datapath
	logic [MAG_W-1:0]        in_mag_raw;
	logic [MAG_W-1:0]        in_mag_sat;
	logic                    s_xfer;
	logic [MAG_W-1:0]        opw_mag;
	logic signed [ACC_W-1:0] opw_val;
	logic signed [ACC_W-1:0] acc_neg_v;
	logic [MAG_W-1:0]        acc_abs;
	logic signed [ACC_W:0]   sum_s;
	logic signed [ACC_W:0]   dif_s;
	logic signed [ACC_W:0]   arith_s;
	logic [26:0]             ir_prod;
	logic [OP_W-1:0]         dec_rem;
	logic [28:0]             shr_prod;
	logic [9:0]              shr_rem;
	logic [MAG_W-1:0]        shr_scaled;
	logic [MAG_W:0]          div_shift;
	logic [MAG_W+1:0]        div_trial;
	logic [MAG_W-1:0]        div_quo_neg;
	logic [PC_W-1:0]         pc_inc;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_xfer        = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;

	// supplied magnitudes above four digits clamp to 9999
	assign in_mag_raw = s_axis_tdata[IN_MAG_LSB +: MAG_W];
	assign in_mag_sat = (in_mag_raw > MAG_MAX) ? MAG_MAX : in_mag_raw;

	// a word never written reads as plus zero
	assign rd_masked = rd_vld_q ? rd_word_q : '0;

	always_comb begin
		opw_mag   = opw_q[MAG_W-1:0];
		opw_val   = opw_q[WORD_W-1] ? -$signed({1'b0, opw_mag}) : $signed({1'b0, opw_mag});
		acc_neg_v = -acc_q;
		acc_abs   = acc_q[ACC_W-1] ? acc_neg_v[MAG_W-1:0] : acc_q[MAG_W-1:0];
		sum_s     = {acc_q[ACC_W-1], acc_q} + {opw_val[ACC_W-1], opw_val};
		dif_s     = {acc_q[ACC_W-1], acc_q} - {opw_val[ACC_W-1], opw_val};
		arith_s   = (op_q == OP_SUB) ? dif_s : sum_s;
		pc_inc    = pc_q + 1'b1;

		// opcode = magnitude / 100, operand = magnitude % 100
		ir_prod = 27'(ir_q[MAG_W-1:0]) * RECIP100;
		dec_rem = OP_W'(ir_q[MAG_W-1:0] - 14'(opq_q) * 14'd100);

		// shift-right instruction keeps the low three digits, then scales by ten
		shr_prod   = 29'(opw_mag) * RECIP1000;
		shr_rem    = 10'(opw_mag - 14'(shr_quo_q) * 14'd1000);
		shr_scaled = 14'(shr_rem_q) * 14'd10;

		// restoring divider, one quotient bit per step
		div_shift   = {div_rem_q, div_quo_q[MAG_W-1]};
		div_trial   = {1'b0, div_shift} - {2'b00, opw_mag};
		div_quo_neg = -div_quo_q;
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_widx  = addr_q[IDX_W-1:0];
		mem_wdata = {item_neg_q, item_mag_q};
		mem_re    = 1'b0;
		mem_ridx  = addr_q[IDX_W-1:0];
		case (state_q)
			S_DISPATCH: begin
				if (addr_q < MW_ADDR) begin
					mem_we = (mode_q == MODE_WRITE);
					mem_re = (mode_q == MODE_READ);
				end
				if (mode_q == MODE_STEP && running_q && pc_q < MW_ADDR) begin
					mem_re   = 1'b1;
					mem_ridx = pc_q[IDX_W-1:0];
				end
			end
			S_OPND_RD: begin
				mem_re   = opnd_ok_q;
				mem_ridx = opnd_q[IDX_W-1:0];
			end
			S_EXEC: begin
				// READ and STORE write the operand cell
				mem_widx = opnd_q[IDX_W-1:0];
				if (op_q == OP_READ) begin
					mem_we = opnd_ok_q;
				end else if (op_q == OP_STORE) begin
					mem_we    = opnd_ok_q;
					mem_wdata = {acc_q[ACC_W-1], acc_abs};
				end
			end
			default: begin
			end
		endcase
	end

	// storage array; one item at a time, so a read never meets a write in flight
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_widx] <= mem_wdata;
		end
		if (mem_re) begin
			rd_word_q <= mem_q[mem_ridx];
		end
	end

	// per-word valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (mem_we) begin
				word_vld_q[mem_widx] <= 1'b1;
			end
			if (mem_re) begin
				rd_vld_q <= word_vld_q[mem_ridx];
			end
		end
	end

	// sequencer with architectural registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			acc_q        <= '0;
			pc_q         <= '0;
			running_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_tdata_q  <= '0;
			mode_q       <= MODE_WRITE;
			addr_q       <= '0;
			item_neg_q   <= 1'b0;
			item_mag_q   <= '0;
			ir_q         <= '0;
			opq_q        <= '0;
			op_q         <= '0;
			opnd_q       <= '0;
			opnd_ok_q    <= 1'b0;
			opw_q        <= '0;
			div_rem_q    <= '0;
			div_quo_q    <= '0;
			div_cnt_q    <= '0;
			div_neg_q    <= 1'b0;
			prod_q       <= '0;
			shr_quo_q    <= '0;
			shr_rem_q    <= '0;
			res_status_q <= ST_OK;
			res_valid_q  <= 1'b0;
			res_word_q   <= '0;
			res_ovf_q    <= 1'b0;
		end else begin
			// downstream takes the pending result; the done state reloads it itself
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						mode_q       <= s_axis_tdata[IN_MODE_LSB +: MODE_W];
						addr_q       <= s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
						item_neg_q   <= s_axis_tdata[IN_NEG_LSB];
						item_mag_q   <= in_mag_sat;
						res_status_q <= ST_OK;
						res_valid_q  <= 1'b0;
						res_word_q   <= '0;
						res_ovf_q    <= 1'b0;
						state_q      <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					case (mode_q)
						MODE_WRITE: begin
							state_q <= S_DONE;
						end
						MODE_READ: begin
							// out-of-range address delivers nothing
							state_q <= (addr_q < MW_ADDR) ? S_RD_DATA : S_DONE;
						end
						MODE_START: begin
							pc_q      <= '0;
							running_q <= 1'b1;
							state_q   <= S_DONE;
						end
						MODE_STEP: begin
							if (!running_q) begin
								res_status_q <= ST_NOT_RUNNING;
								state_q      <= S_DONE;
							end else if (pc_q >= MW_ADDR) begin
								// fell off the end or branched outside memory
								res_status_q <= ST_PAST_END;
								running_q    <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_IR_DATA;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end

				S_RD_DATA: begin
					res_valid_q <= 1'b1;
					res_word_q  <= rd_masked;
					state_q     <= S_DONE;
				end

				S_IR_DATA: begin
					ir_q    <= rd_masked;
					state_q <= S_DEC_Q;
				end

				S_DEC_Q: begin
					opq_q   <= ir_prod[19 +: OP_W];
					state_q <= S_DEC_R;
				end

				S_DEC_R: begin
					// data words (minus sign) decode as no operation
					op_q      <= ir_q[WORD_W-1] ? '0 : opq_q;
					opnd_q    <= dec_rem;
					opnd_ok_q <= (dec_rem < MW_ADDR);
					state_q   <= S_OPND_RD;
				end

				S_OPND_RD: begin
					state_q <= S_OPND_DATA;
				end

				S_OPND_DATA: begin
					// operands outside memory read as plus zero
					opw_q   <= opnd_ok_q ? rd_masked : '0;
					state_q <= S_EXEC;
				end

				S_EXEC: begin
					case (op_q)
						OP_READ, OP_STORE: begin
							pc_q    <= pc_inc;
							state_q <= S_DONE;
						end
						OP_WRITE: begin
							res_valid_q <= 1'b1;
							res_word_q  <= opw_q;
							pc_q        <= pc_inc;
							state_q     <= S_DONE;
						end
						OP_LOAD: begin
							acc_q   <= opw_val;
							pc_q    <= pc_inc;
							state_q <= S_DONE;
						end
						OP_ADD, OP_SUB: begin
							pc_q    <= pc_inc;
							state_q <= S_DONE;
							if (arith_s > SUM_MAX) begin
								acc_q     <= ACC_MAX;
								res_ovf_q <= 1'b1;
							end else if (arith_s < SUM_MIN) begin
								acc_q     <= ACC_MIN;
								res_ovf_q <= 1'b1;
							end else begin
								acc_q <= arith_s[ACC_W-1:0];
							end
						end
						OP_DIV: begin
							if (opw_mag == '0) begin
								// divide by zero stops the run on the DIV
								res_status_q <= ST_DIV_ZERO;
								running_q    <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								div_rem_q <= '0;
								div_quo_q <= acc_abs;
								div_cnt_q <= '0;
								div_neg_q <= acc_q[ACC_W-1] ^ opw_q[WORD_W-1];
								pc_q      <= pc_inc;
								state_q   <= S_DIV_STEP;
							end
						end
						OP_MUL: begin
							prod_q  <= acc_q * opw_val;
							pc_q    <= pc_inc;
							state_q <= S_MUL_SAT;
						end
						OP_BRANCH: begin
							pc_q    <= opnd_q;
							state_q <= S_DONE;
						end
						OP_BRNEG: begin
							pc_q    <= acc_q[ACC_W-1] ? opnd_q : pc_inc;
							state_q <= S_DONE;
						end
						OP_BRZERO: begin
							pc_q    <= (acc_q == '0) ? opnd_q : pc_inc;
							state_q <= S_DONE;
						end
						OP_HALT: begin
							// pc stays on the HALT
							res_status_q <= ST_HALTED;
							running_q    <= 1'b0;
							state_q      <= S_DONE;
						end
						OP_SHR: begin
							pc_q    <= pc_inc;
							state_q <= S_SHR_Q;
						end
						default: begin
							pc_q    <= pc_inc;
							state_q <= S_DONE;
							// zero words and data words skip quietly
							if (!ir_q[WORD_W-1] && ir_q[MAG_W-1:0] != '0) begin
								res_status_q <= ST_UNKNOWN;
							end
						end
					endcase
				end

				S_DIV_STEP: begin
					if (!div_trial[MAG_W+1]) begin
						div_rem_q <= div_trial[MAG_W-1:0];
						div_quo_q <= {div_quo_q[MAG_W-2:0], 1'b1};
					end else begin
						div_rem_q <= div_shift[MAG_W-1:0];
						div_quo_q <= {div_quo_q[MAG_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_DIV_DONE;
					end
				end

				S_DIV_DONE: begin
					// truncating quotient, sign from both operands
					acc_q   <= div_neg_q ? $signed({div_quo_neg[MAG_W-1], div_quo_neg})
					                     : $signed({1'b0, div_quo_q});
					state_q <= S_DONE;
				end

				S_MUL_SAT: begin
					if (prod_q > PROD_MAX) begin
						acc_q     <= ACC_MAX;
						res_ovf_q <= 1'b1;
					end else if (prod_q < PROD_MIN) begin
						acc_q     <= ACC_MIN;
						res_ovf_q <= 1'b1;
					end else begin
						acc_q <= prod_q[ACC_W-1:0];
					end
					state_q <= S_DONE;
				end

				S_SHR_Q: begin
					shr_quo_q <= shr_prod[24 +: 4];
					state_q   <= S_SHR_R;
				end

				S_SHR_R: begin
					shr_rem_q <= shr_rem;
					state_q   <= S_SHR_SCALE;
				end

				S_SHR_SCALE: begin
					// remainder keeps the sign of the operand word
					acc_q   <= opw_q[WORD_W-1] ? -$signed({1'b0, shr_scaled})
					                           : $signed({1'b0, shr_scaled});
					state_q <= S_DONE;
				end

				S_DONE: begin
					// wait here only while an older result is still not taken
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_tdata_q <= {{OUT_PAD_W{1'b0}}, res_ovf_q, acc_q, pc_q,
							res_word_q[MAG_W-1:0], res_word_q[WORD_W-1], res_valid_q,
							res_status_q};
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/dam_checker.sv */
module dam_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dam_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dam_pkg::*;

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;
	logic signed [ACC_W-1:0] acc_v;

	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_xfer = m_axis_tvalid & m_axis_tready;
	assign acc_v    = $signed(m_axis_tdata[OUT_ACC_LSB +: ACC_W]);

	// items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a result only answers an item already taken
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result shown with no pending item");

	// one item in work plus one result parked at most
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

	a_word_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[OUT_VALID_LSB] |->
			!m_axis_tdata[OUT_NEG_LSB] && m_axis_tdata[OUT_MAG_LSB +: MAG_W] == '0)
		else $error("word fields set without a delivered word");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_OVF_LSB] |->
			acc_v == 15'sd9999 || acc_v == -15'sd9999)
		else $error("overflow flagged with unsaturated accumulator");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/tb_decimal_accumulator_machine.sv */
module tb_decimal_accumulator_machine;
	timeunit 1ns;
	timeprecision 1ps;

	import dam_pkg::*;

	localparam int MEMORY_WORDS = 100;
	localparam int WORD_LIMIT   = 9999;
	localparam int CYCLE_LIMIT  = 1000000;

	// one input transfer, laid out exactly as s_axis_tdata (mode in the lowest bits)
	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic              neg;
		logic [ADDR_W-1:0] addr;
		logic [MODE_W-1:0] mode;
	} machine_item_t;

	// one result transfer, field by field
	typedef struct packed {
		status_t           status;
		logic              out_valid;
		logic              out_neg;
		logic [MAG_W-1:0]  out_mag;
		logic [PC_W-1:0]   pc;
		logic [ACC_W-1:0]  acc;
		logic              ovf;
	} step_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow copy of the machine state
	word_t words [MEMORY_WORDS];
	int    acc;
	int    pc;
	logic  running;

	machine_item_t item_q [$];     // items waiting to be offered
	step_result_t  outcome_q [$];  // predicted results, oldest first
	machine_item_t offered = '0;   // item currently on the input bus
	step_result_t  predicted;

	bit in_done  = 1'b0;           // input transfer at the last rising edge
	bit out_done = 1'b0;           // output transfer at the last rising edge
	int send_gap = 0;
	int send_calm = 0;
	int take_gap = 0;
	int take_calm = 0;
	int hold_cycles = 0;           // long receiver hold-off, counted down by the receiver
	int counted_items = 0;
	int result_index = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	decimal_accumulator_machine #(
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// sign-magnitude word, magnitude clipped to four decimal digits
	function automatic word_t pack_word(input logic neg, input int mag);
		logic [MAG_W-1:0] m;
		m = (mag > WORD_LIMIT) ? MAG_MAX : mag[MAG_W-1:0];
		return {neg, m};
	endfunction

	function automatic int word_value(input word_t w);
		return w[WORD_W-1] ? -int'(w[MAG_W-1:0]) : int'(w[MAG_W-1:0]);
	endfunction

	function automatic int saturate_acc(input int raw, output logic hit);
		hit = (raw > WORD_LIMIT) || (raw < -WORD_LIMIT);
		if (raw > WORD_LIMIT)
			return WORD_LIMIT;
		if (raw < -WORD_LIMIT)
			return -WORD_LIMIT;
		return raw;
	endfunction

	// one item through the machine: updates the shadow state, gives the result
	task automatic machine_step(input machine_item_t it, output step_result_t r);
		word_t            given;
		word_t            ir;
		word_t            operand_word;
		logic [OP_W-1:0]  op;
		int               opnd;
		int               v;
		int               nxt;
		logic             hit;
		given = pack_word(it.neg, int'(it.mag));
		r = '0;
		hit = 1'b0;
		case (it.mode)
			MODE_WRITE: begin
				// writes beyond memory are dropped
				if (it.addr < MEMORY_WORDS)
					words[it.addr] = given;
			end
			MODE_READ: begin
				if (it.addr < MEMORY_WORDS) begin
					r.out_valid = 1'b1;
					r.out_neg   = words[it.addr][WORD_W-1];
					r.out_mag   = words[it.addr][MAG_W-1:0];
				end
			end
			MODE_START: begin
				// accumulator survives a restart
				pc = 0;
				running = 1'b1;
			end
			default: begin
				if (!running) begin
					r.status = ST_NOT_RUNNING;
				end else if (pc >= MEMORY_WORDS) begin
					r.status = ST_PAST_END;
					running = 1'b0;
				end else begin
					ir = words[pc];
					// minus words are data, never instructions
					op = ir[WORD_W-1] ? '0 : OP_W'(ir[MAG_W-1:0] / 100);
					opnd = ir[MAG_W-1:0] % 100;
					operand_word = (opnd < MEMORY_WORDS) ? words[opnd] : '0;
					v = word_value(operand_word);
					nxt = pc + 1;
					case (op)
						OP_READ: begin
							if (opnd < MEMORY_WORDS)
								words[opnd] = given;
						end
						OP_WRITE: begin
							r.out_valid = 1'b1;
							r.out_neg   = operand_word[WORD_W-1];
							r.out_mag   = operand_word[MAG_W-1:0];
						end
						OP_LOAD: acc = v;
						OP_STORE: begin
							if (opnd < MEMORY_WORDS)
								words[opnd] = pack_word(acc < 0, (acc < 0) ? -acc : acc);
						end
						OP_ADD: acc = saturate_acc(acc + v, hit);
						OP_SUB: acc = saturate_acc(acc - v, hit);
						OP_DIV: begin
							// minus zero divides by zero as well
							if (v == 0) begin
								r.status = ST_DIV_ZERO;
								running = 1'b0;
								nxt = pc;
							end else begin
								acc = acc / v;
							end
						end
						OP_MUL: acc = saturate_acc(acc * v, hit);
						OP_BRANCH: nxt = opnd;
						OP_BRNEG: begin
							if (acc < 0)
								nxt = opnd;
						end
						OP_BRZERO: begin
							if (acc == 0)
								nxt = opnd;
						end
						OP_HALT: begin
							r.status = ST_HALTED;
							running = 1'b0;
							nxt = pc;
						end
						// remainder keeps the sign of the word
						OP_SHR: acc = (v % 1000) * 10;
						default: begin
							// zero and data words pass silently, other positive words are flagged
							if (!ir[WORD_W-1] && ir[MAG_W-1:0] != 0)
								r.status = ST_UNKNOWN;
						end
					endcase
					pc = nxt;
				end
			end
		endcase
		r.pc  = pc[PC_W-1:0];
		r.acc = acc[ACC_W-1:0];
		r.ovf = hit;
	endtask

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("result %0d: %s is %0d, should be %0d", result_index, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// idle length: mostly none or short, now and then long, with calm stretches
	function automatic int idle_len(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// data magnitudes: small, near the top, above the top, anything
	function automatic int random_magnitude();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 20);
			1: return $urandom_range(9000, 9999);
			2: return $urandom_range(10000, 16383);
			default: return $urandom_range(0, 9999);
		endcase
	endfunction

	function automatic int instr_mag(input int op, input int opnd);
		return op * 100 + opnd;
	endfunction

	function automatic int opcode_at(input int i);
		case (i)
			0: return OP_READ;
			1: return OP_WRITE;
			2: return OP_LOAD;
			3: return OP_STORE;
			4: return OP_ADD;
			5: return OP_SUB;
			6: return OP_DIV;
			7: return OP_MUL;
			8: return OP_BRANCH;
			9: return OP_BRNEG;
			10: return OP_BRZERO;
			11: return OP_HALT;
			default: return OP_SHR;
		endcase
	endfunction

	task automatic push_item(input int mode, input int addr, input int neg, input int mag);
		machine_item_t it;
		it.mode = MODE_W'(mode);
		it.addr = ADDR_W'(addr);
		it.neg  = neg[0];
		it.mag  = MAG_W'(mag);
		item_q.push_back(it);
		// writes beyond memory change nothing and do not count
		if (!(it.mode == MODE_WRITE && addr >= MEMORY_WORDS))
			counted_items++;
	endtask

	// one program word: mostly real instructions, some data, zero or unknown words
	task automatic queue_program_word(input int at, input int len);
		int pick;
		int op;
		int opnd;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			push_item(MODE_WRITE, at, 1, random_magnitude());
		end else if (pick < 10) begin
			push_item(MODE_WRITE, at, 0, 0);
		end else begin
			op = (pick < 90) ? opcode_at($urandom_range(0, 12)) : $urandom_range(0, 99);
			pick = $urandom_range(0, 9);
			if (op == OP_BRANCH || op == OP_BRNEG || op == OP_BRZERO)
				// branch back into the program, near the end of memory, or anywhere
				opnd = (pick < 7) ? $urandom_range(0, len - 1) :
					(pick < 9) ? $urandom_range(90, 99) : $urandom_range(0, 99);
			else
				opnd = (pick < 7) ? $urandom_range(60, 99) : $urandom_range(0, 99);
			push_item(MODE_WRITE, at, 0, instr_mag(op, opnd));
		end
	endtask

	// a loaded program with data, a start and a run of steps; now and then pure noise
	task automatic queue_session();
		int len;
		int steps;
		if ($urandom_range(0, 9) < 8) begin
			len = $urandom_range(3, 16);
			for (int a = 0; a < len; a++)
				queue_program_word(a, len);
			repeat ($urandom_range(3, 8))
				push_item(MODE_WRITE, $urandom_range(60, 99), $urandom_range(0, 1),
					random_magnitude());
			push_item(MODE_START, $urandom_range(0, 127), $urandom_range(0, 1),
				$urandom_range(0, 16383));
			// a few long runs to fall off the end of memory
			steps = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 130) :
				$urandom_range(len, 3 * len + 10);
			repeat (steps) begin
				// memory traffic in the middle of a run
				if ($urandom_range(0, 9) == 0)
					push_item($urandom_range(0, 1), $urandom_range(0, 127),
						$urandom_range(0, 1), $urandom_range(0, 16383));
				push_item(MODE_STEP, $urandom_range(0, 127), $urandom_range(0, 1),
					random_magnitude());
			end
		end else begin
			repeat ($urandom_range(4, 15))
				push_item($urandom_range(0, 3), $urandom_range(0, 127),
					$urandom_range(0, 1), $urandom_range(0, 16383));
		end
	endtask

	// sender stops until the block has delivered everything
	task automatic wait_drained();
		while (item_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// driver, acceptance, receiver, monitor
	// ---------------------------------------------------------------

	// sender: next item or an idle gap once the current one has transferred
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_done || !s_axis_tvalid) begin
				in_done = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (item_q.size() > 0) begin
					offered = item_q.pop_front();
					s_axis_tdata <= offered;
					s_axis_tvalid <= 1'b1;
					send_gap = idle_len(send_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// input transfer: predict its result right away
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			machine_step(offered, predicted);
			outcome_q.push_back(predicted);
			in_done = 1'b1;
		end
	end

	// receiver: stalls after transfers and at random, plus the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_done) begin
				out_done = 1'b0;
				take_gap = idle_len(take_calm);
			end else if (take_gap == 0 && $urandom_range(0, 9) == 0) begin
				take_gap = idle_len(take_calm);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// output transfer: compare with the oldest prediction
	always @(posedge clk) begin : monitor
		step_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			out_done = 1'b1;
			result_index++;
			if (outcome_q.size() == 0) begin
				report_mismatch("unexpected result, low bits", m_axis_tdata[31:0], '0);
			end else begin
				want = outcome_q.pop_front();
				check_field("status", m_axis_tdata[OUT_STAT_LSB +: STAT_W], want.status);
				check_field("out_valid", m_axis_tdata[OUT_VALID_LSB], want.out_valid);
				check_field("out_negative", m_axis_tdata[OUT_NEG_LSB], want.out_neg);
				check_field("out_magnitude", m_axis_tdata[OUT_MAG_LSB +: MAG_W], want.out_mag);
				check_field("program_counter", m_axis_tdata[OUT_PC_LSB +: PC_W], want.pc);
				check_field("acc_value", m_axis_tdata[OUT_ACC_LSB +: ACC_W], want.acc);
				check_field("overflow", m_axis_tdata[OUT_OVF_LSB], want.ovf);
				check_field("padding", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], '0);
			end
		end
	end

	// hard stop
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		foreach (words[i])
			words[i] = '0;
		acc = 0;
		pc = 0;
		running = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fresh memory reads plus zero, stepping before any start
		push_item(MODE_READ, 0, 0, 0);
		push_item(MODE_STEP, 0, 0, 0);
		// oversized magnitude clips, out-of-range write is dropped and read is empty
		push_item(MODE_WRITE, 99, 0, 16383);
		push_item(MODE_WRITE, 127, 1, 16383);
		push_item(MODE_READ, 127, 0, 0);
		// minus zero as a divisor
		push_item(MODE_WRITE, 98, 1, 0);

		// first program walks through the arithmetic and branches
		push_item(MODE_WRITE, 0, 0, instr_mag(OP_READ, 97));
		push_item(MODE_WRITE, 1, 0, instr_mag(OP_LOAD, 97));
		push_item(MODE_WRITE, 2, 0, instr_mag(OP_MUL, 99));
		push_item(MODE_WRITE, 3, 0, instr_mag(OP_BRNEG, 5));
		push_item(MODE_WRITE, 5, 0, instr_mag(OP_DIV, 99));
		push_item(MODE_WRITE, 6, 0, instr_mag(OP_SUB, 99));
		push_item(MODE_WRITE, 7, 0, instr_mag(OP_STORE, 96));
		push_item(MODE_WRITE, 8, 0, instr_mag(OP_WRITE, 96));
		push_item(MODE_WRITE, 9, 0, instr_mag(OP_ADD, 99));
		push_item(MODE_WRITE, 10, 0, instr_mag(OP_BRZERO, 12));
		push_item(MODE_WRITE, 12, 0, instr_mag(OP_SHR, 99));
		push_item(MODE_WRITE, 13, 0, instr_mag(OP_BRANCH, 15));
		push_item(MODE_WRITE, 15, 0, instr_mag(OP_DIV, 98));
		push_item(MODE_START, 0, 0, 0);
		// the READ takes the most negative word the bus can carry
		push_item(MODE_STEP, 0, 1, 16383);
		repeat (11)
			push_item(MODE_STEP, 0, 0, 0);

		// second program: data word skipped, unknown words, running off the end
		push_item(MODE_WRITE, 0, 0, instr_mag(OP_BRANCH, 16));
		push_item(MODE_WRITE, 16, 1, 1234);
		push_item(MODE_WRITE, 17, 0, 50);
		push_item(MODE_WRITE, 18, 0, instr_mag(OP_BRANCH, 99));
		push_item(MODE_START, 0, 0, 0);
		repeat (6)
			push_item(MODE_STEP, 0, 0, 0);

		// halt, then a step after the run has stopped
		push_item(MODE_WRITE, 0, 0, instr_mag(OP_HALT, 0));
		push_item(MODE_START, 0, 0, 0);
		push_item(MODE_STEP, 0, 0, 0);
		push_item(MODE_STEP, 0, 0, 0);

		// sender pause until everything is back
		wait_drained();
		counted_items = 0;

		// receiver holds off while the sender keeps offering
		repeat (4)
			queue_session();
		hold_cycles = 400;
		while (counted_items < 600)
			queue_session();

		// second pause halfway through
		wait_drained();
		while (counted_items < 1200)
			queue_session();

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dam_pkg.sv
rtl/core/decimal_accumulator_machine.sv
rtl/core/dam_checker.sv
tb/sv/tb_decimal_accumulator_machine.sv
